/* rtl/hse_pkg.sv */
// Shared types for the heap sort engine.
`timescale 1ns / 1ps
package hse_pkg;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_BUILD,
		ST_BUILD_V,
		ST_SORT,
		ST_SORT_RD,
		ST_SORT_V,
		ST_RD_L,
		ST_RD_R,
		ST_CMP,
		ST_EMIT_RD,
		ST_EMIT_LD
	} hse_state_t;

endpackage

/* rtl/heap_sort_engine.sv */
// Heap sort engine: loads a set, heap-sorts it in one synchronous store, emits ascending.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------
//  item    | item_valid / item_stall    | value_in, is_last
//  result  | result_valid / result_stall| sorted_value, last_out
//
// Loading writes each accepted item into the store. The sort runs in one synchronous memory
// with one read and one write per cycle: each sift level reads the left child, reads the
// right child, then compares and moves; each extraction moves the root to the last slot,
// shrinks the heap and sifts the old last value down; values are then read out in order.
// item_stall is high from the closing item until the last result has been loaded.
// A stalled result holds in the output register; arst_n clears all control state.
`timescale 1ns / 1ps
module heap_sort_engine
	import hse_pkg::*;
#(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] value_in,
	input  logic               is_last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] sorted_value,
	output logic               last_out
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = AW + 2;

	hse_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] mem [MAX_ITEMS];
	logic [VALUE_WIDTH-1:0] rd_q;
	logic                   re, we;
	logic [AW-1:0]          ra, wa;
	logic [VALUE_WIDTH-1:0] wd;

	logic [CW-1:0]          cnt_q, n_q, hs_q;
	logic [AW-1:0]          bi_q, last_q, pos_q, eidx_q;
	logic [VALUE_WIDTH-1:0] v_q, lv_q;
	logic                   in_sort_q;
	logic                   out_valid_q, out_last_q;
	logic [31:0]            out_val_q;

	logic                   accept, closing, out_free, emit_last;
	logic [CW-1:0]          n_next;
	logic [IW-1:0]          left_w, right_w, hs_w, child_w;
	logic                   left_ok, right_ok, right_big, move;
	logic [VALUE_WIDTH-1:0] in_val, child_v;
	hse_state_t             sift_done;

	assign accept    = item_valid && !item_stall;
	assign n_next    = cnt_q + 1'b1;
	assign closing   = is_last || (cnt_q == CW'(MAX_ITEMS - 1));
	assign in_val    = VALUE_WIDTH'($unsigned(value_in));
	assign out_free  = !out_valid_q || !result_stall;
	assign emit_last = (CW'(eidx_q) == (n_q - 1'b1));

	assign left_w    = {1'b0, pos_q, 1'b1};
	assign right_w   = left_w + 1'b1;
	assign hs_w      = IW'(hs_q);
	assign left_ok   = left_w < hs_w;
	assign right_ok  = right_w < hs_w;
	assign right_big = right_ok && ($signed(rd_q) > $signed(lv_q));
	assign child_v   = right_big ? rd_q : lv_q;
	assign child_w   = right_big ? right_w : left_w;
	assign move      = $signed(child_v) > $signed(v_q);
	assign sift_done = in_sort_q ? ST_SORT : ST_BUILD;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:    if (accept && closing) state_d = ST_BUILD;
			ST_BUILD:   state_d = (bi_q == '0) ? ST_SORT : ST_BUILD_V;
			ST_BUILD_V: state_d = ST_RD_L;
			ST_SORT:    state_d = (last_q == '0) ? ST_EMIT_RD : ST_SORT_RD;
			ST_SORT_RD: state_d = ST_SORT_V;
			ST_SORT_V:  state_d = ST_RD_L;
			ST_RD_L:    state_d = left_ok ? ST_RD_R : sift_done;
			ST_RD_R:    state_d = ST_CMP;
			ST_CMP:     state_d = move ? ST_RD_L : sift_done;
			ST_EMIT_RD: state_d = ST_EMIT_LD;
			ST_EMIT_LD: if (out_free) state_d = emit_last ? ST_LOAD : ST_EMIT_RD;
			default:    state_d = ST_LOAD;
		endcase
	end

	// memory controls
	always_comb begin
		item_stall = 1'b1;
		re = 1'b0;
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = v_q;
		case (state_q)
			ST_LOAD: begin
				item_stall = 1'b0;
				we = accept;
				wa = cnt_q[AW-1:0];
				wd = in_val;
			end
			ST_BUILD: begin
				re = (bi_q != '0);
				ra = bi_q - 1'b1;
			end
			ST_SORT: begin
				re = (last_q != '0);
				ra = '0;
			end
			ST_SORT_RD: begin
				re = 1'b1;
				ra = last_q;
				we = 1'b1;
				wa = last_q;
				wd = rd_q;
			end
			ST_RD_L: begin
				re = left_ok;
				ra = left_w[AW-1:0];
				we = !left_ok;
				wa = pos_q;
				wd = v_q;
			end
			ST_RD_R: begin
				re = right_ok;
				ra = right_w[AW-1:0];
			end
			ST_CMP: begin
				we = 1'b1;
				wa = pos_q;
				wd = move ? child_v : v_q;
			end
			ST_EMIT_RD: begin
				re = 1'b1;
				ra = eidx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			hs_q        <= '0;
			bi_q        <= '0;
			last_q      <= '0;
			pos_q       <= '0;
			eidx_q      <= '0;
			in_sort_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !result_stall && state_q != ST_EMIT_LD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (closing) begin
							cnt_q     <= '0;
							n_q       <= n_next;
							hs_q      <= n_next;
							bi_q      <= AW'(n_next >> 1);
							in_sort_q <= 1'b0;
						end else begin
							cnt_q <= n_next;
						end
					end
				end
				ST_BUILD: begin
					if (bi_q == '0) begin
						in_sort_q <= 1'b1;
						last_q    <= AW'(n_q - 1'b1);
					end else begin
						bi_q <= bi_q - 1'b1;
					end
				end
				ST_BUILD_V: begin
					pos_q <= bi_q;
				end
				ST_SORT: begin
					eidx_q <= '0;
				end
				ST_SORT_V: begin
					pos_q  <= '0;
					hs_q   <= CW'(last_q);
					last_q <= last_q - 1'b1;
				end
				ST_CMP: begin
					if (move) begin
						pos_q <= child_w[AW-1:0];
					end
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= emit_last;
						eidx_q      <= eidx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// sift value, left child and output value, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_BUILD_V: v_q <= rd_q;
			ST_SORT_V:  v_q <= rd_q;
			ST_RD_R:    lv_q <= rd_q;
			ST_EMIT_LD: begin
				if (out_free) begin
					out_val_q <= 32'($unsigned(rd_q));
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign sorted_value = out_val_q;
	assign last_out     = out_last_q;

endmodule
